/* rtl/core/assert_macros.svh */
// Assertion macros included by the compressor top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/lzw_pkg.sv */
// Package: constants and types of the LZW compressor.
package lzw_pkg;
  localparam int CODE_W      = 12;
  localparam int BYTE_W      = 8;
  localparam int KEY_W       = CODE_W + BYTE_W;
  localparam int NFC_W       = CODE_W + 1;
  localparam int DICT_DEPTH  = 1 << CODE_W;
  localparam int CODE_LIMIT  = 4095;
  localparam int TOP_CODE    = (CODE_LIMIT < DICT_DEPTH) ? CODE_LIMIT : DICT_DEPTH - 1;
  localparam logic [CODE_W-1:0] EOS_CODE      = CODE_W'(256);
  localparam logic [NFC_W-1:0]  LITERAL_CODES = NFC_W'(256);
  localparam logic [NFC_W-1:0]  FIRST_FREE    = LITERAL_CODES + NFC_W'(1);
  localparam logic [NFC_W-1:0]  TOP_CODE_V    = NFC_W'(TOP_CODE);

  typedef struct packed {
    logic                        load;
    logic [1:0]                  cnt;
    logic [2:0][CODE_W-1:0]      codes;
  } oq_load_t;
endpackage

/* rtl/core/lzw_oq.sv */
// Output queue: holds up to three codes of one byte and hands them out in order.
module lzw_oq
  import lzw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  oq_load_t          ld,
  output logic              empty,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_code,
  output logic              out_last_of_run
);
  logic [1:0]             cnt_r, cnt_nxt;
  logic [2:0][CODE_W-1:0] q_r, q_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    if (ld.load) begin
      cnt_nxt = ld.cnt;
      q_nxt   = ld.codes;
    end else if (out_valid && !out_stall) begin
      cnt_nxt = cnt_r - 2'd1;
      q_nxt   = {CODE_W'(0), q_r[2], q_r[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
  end

  assign empty           = (cnt_r == 2'd0);
  assign out_valid       = !empty;
  assign out_code        = q_r[0];
  assign out_last_of_run = (cnt_r == 2'd1);
endmodule

/* rtl/core/lzw_byte_compressor_top.sv */
// Top level: LZW byte compressor with a linearly scanned dictionary memory.
// Usage:
//   Input channel in_valid/in_stall carries one word: in_data_byte and
//   in_end_of_input (set on the final byte of a stream).
//   Output channel out_valid/out_stall carries out_code and out_last_of_run,
//   which marks the final code caused by one input byte.
//   A byte causes zero to three codes; the last byte of a stream adds the
//   pending code and the end marker 256, then the dictionary is emptied.
// Timing:
//   A byte with no pending prefix, or with an empty dictionary, goes from
//   idle straight to the finish state. Otherwise the dictionary is scanned
//   one entry per cycle through the single read port of the memory, codes
//   257 to n - 1, where n is the next free code; a hit ends the scan early.
//   Codes leave at one per cycle while out_stall is low; a new byte is
//   taken only when idle and all codes of the previous byte have gone.
// Reset: empties the dictionary and prefix at once (a fill count marks the
//   valid entries), no clearing pass.
// Stall: codes wait in the output queue; in_stall stays high meanwhile.
module lzw_byte_compressor_top
  import lzw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_input,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_code,
  output logic              out_last_of_run
);
`include "assert_macros.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_FINISH} state_t;

  state_t              state_r, state_nxt;
  logic [CODE_W-1:0]   prefix_r, prefix_nxt;
  logic                pvalid_r, pvalid_nxt;
  logic [NFC_W-1:0]    nfc_r, nfc_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic                last_r, last_nxt;
  logic                first_r, first_nxt;
  logic                hit_r, hit_nxt;
  logic [CODE_W-1:0]   hcode_r, hcode_nxt;
  logic [NFC_W-1:0]    scan_r, scan_nxt;
  logic                iss_r, iss_nxt;
  logic                cmpv_r, cmpv_nxt;
  logic [NFC_W-1:0]    cmpa_r, cmpa_nxt;
  logic [KEY_W-1:0]    rdata_r;
  logic [KEY_W-1:0]    mem [DICT_DEPTH];
  logic                we;
  logic [KEY_W-1:0]    key;
  logic [NFC_W-1:0]    last_idx;
  logic                oq_empty;
  logic                in_acc;
  oq_load_t            ld;

  assign key      = {prefix_r, byte_r};
  assign last_idx = nfc_r - NFC_W'(1);
  assign in_stall = (state_r != ST_IDLE) || !oq_empty;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    logic [1:0]        n;
    logic [CODE_W-1:0] p;
    n          = 2'd0;
    p          = prefix_r;
    state_nxt  = state_r;
    prefix_nxt = prefix_r;
    pvalid_nxt = pvalid_r;
    nfc_nxt    = nfc_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    first_nxt  = first_r;
    hit_nxt    = hit_r;
    hcode_nxt  = hcode_r;
    scan_nxt   = scan_r;
    iss_nxt    = iss_r;
    cmpv_nxt   = 1'b0;
    cmpa_nxt   = cmpa_r;
    we         = 1'b0;
    ld         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          byte_nxt  = in_data_byte;
          last_nxt  = in_end_of_input;
          first_nxt = !pvalid_r;
          hit_nxt   = 1'b0;
          scan_nxt  = FIRST_FREE;
          iss_nxt   = 1'b1;
          state_nxt = (!pvalid_r || nfc_r == FIRST_FREE) ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (iss_r) begin
          cmpv_nxt = 1'b1;
          cmpa_nxt = scan_r;
          if (scan_r == last_idx) iss_nxt = 1'b0;
          else scan_nxt = scan_r + NFC_W'(1);
        end
        if (cmpv_r && rdata_r == key) begin
          hit_nxt   = 1'b1;
          hcode_nxt = cmpa_r[CODE_W-1:0];
          cmpv_nxt  = 1'b0;
          iss_nxt   = 1'b0;
          state_nxt = ST_FINISH;
        end else if (cmpv_r && cmpa_r == last_idx) begin
          cmpv_nxt  = 1'b0;
          iss_nxt   = 1'b0;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (first_r) begin
          p = CODE_W'(byte_r);
        end else if (hit_r) begin
          p = hcode_r;
        end else begin
          if (nfc_r <= TOP_CODE_V) begin
            we      = 1'b1;
            nfc_nxt = nfc_r + NFC_W'(1);
          end
          ld.codes[n] = prefix_r;
          n = n + 2'd1;
          p = CODE_W'(byte_r);
        end
        prefix_nxt = p;
        pvalid_nxt = 1'b1;
        if (last_r) begin
          ld.codes[n] = p;
          n = n + 2'd1;
          ld.codes[n] = EOS_CODE;
          n = n + 2'd1;
          prefix_nxt = '0;
          pvalid_nxt = 1'b0;
          nfc_nxt    = FIRST_FREE;
        end
        ld.cnt    = n;
        ld.load   = (n != 2'd0);
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      prefix_r <= '0;
      pvalid_r <= 1'b0;
      nfc_r    <= FIRST_FREE;
      iss_r    <= 1'b0;
      cmpv_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      prefix_r <= prefix_nxt;
      pvalid_r <= pvalid_nxt;
      nfc_r    <= nfc_nxt;
      iss_r    <= iss_nxt;
      cmpv_r   <= cmpv_nxt;
    end
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    first_r <= first_nxt;
    hit_r   <= hit_nxt;
    hcode_r <= hcode_nxt;
    scan_r  <= scan_nxt;
    cmpa_r  <= cmpa_nxt;
  end

  // dictionary: one write port (insert), one registered read port (scan)
  always_ff @(posedge clk) begin
    if (we) mem[nfc_r[CODE_W-1:0]] <= key;
    rdata_r <= mem[scan_r[CODE_W-1:0]];
  end

  lzw_oq u_oq (
    .clk             (clk),
    .rst_n           (rst_n),
    .ld              (ld),
    .empty           (oq_empty),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code        (out_code),
    .out_last_of_run (out_last_of_run)
  );

  `ASSERT_CLK(a_busy_queue_empty, (state_r != ST_IDLE) |-> oq_empty, "queue busy during byte work")
  `ASSERT_CLK(a_nfc_range, (nfc_r >= FIRST_FREE) && (nfc_r <= TOP_CODE_V + NFC_W'(1)), "free code out of range")
  `ASSERT_CLK(a_scan_bound, cmpv_r |-> (cmpa_r >= FIRST_FREE) && (cmpa_r <= last_idx), "scan past fill")
  `ASSERT_CLK(a_search_needs_prefix, (state_r == ST_SEARCH) |-> pvalid_r, "search without prefix")
endmodule

/* tb/tb_lzw_byte_compressor_top.sv */
// Testbench for the LZW byte compressor: predicts codes per byte and checks each output word.
module tb_lzw_byte_compressor_top;
  import lzw_pkg::*;

  localparam int CYCLE_LIMIT = 30000000;
  localparam int SCAN_WAIT   = DICT_DEPTH + 64;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              last;
  } code_word_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_data_byte;
  logic              in_end_of_input;
  logic              out_valid;
  logic              out_stall;
  logic [CODE_W-1:0] out_code;
  logic              out_last_of_run;

  // predictor state
  logic [CODE_W-1:0] cur_prefix;
  logic              have_prefix;
  logic [NFC_W-1:0]  free_code;
  logic [KEY_W-1:0]  dict_key [DICT_DEPTH];
  bit                dict_used [DICT_DEPTH];

  code_word_t expected_codes[$];
  int         sender_idle_pct;
  int         receiver_stall_pct;
  int         hold_left;
  int         cycle_count;
  bit         failed;

  lzw_byte_compressor_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_end_of_input(in_end_of_input),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code(out_code), .out_last_of_run(out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic clear_dictionary();
    cur_prefix = '0;
    have_prefix = 1'b0;
    free_code = FIRST_FREE;
    for (int n = 0; n < DICT_DEPTH; n++) dict_used[n] = 1'b0;
  endtask

  task automatic compress_byte(input logic [BYTE_W-1:0] b, input logic eoi);
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] emitted [3];
    int                cnt;
    int                hit;
    int                scan_end;
    cnt = 0;
    if (!have_prefix) begin
      cur_prefix = CODE_W'(b);
      have_prefix = 1'b1;
    end else begin
      key = {cur_prefix, b};
      hit = -1;
      scan_end = (free_code < DICT_DEPTH) ? int'(free_code) : DICT_DEPTH;
      for (int n = int'(FIRST_FREE); n < scan_end; n++)
        if (hit < 0 && dict_used[n] && dict_key[n] == key) hit = n;
      if (hit >= 0) begin
        cur_prefix = CODE_W'(hit);
      end else begin
        if (free_code <= TOP_CODE_V) begin
          dict_key[free_code[CODE_W-1:0]] = key;
          dict_used[free_code[CODE_W-1:0]] = 1'b1;
          free_code++;
        end
        emitted[cnt++] = cur_prefix;
        cur_prefix = CODE_W'(b);
      end
    end
    if (eoi) begin
      emitted[cnt++] = cur_prefix;
      emitted[cnt++] = EOS_CODE;
      clear_dictionary();
    end
    for (int i = 0; i < cnt; i++)
      expected_codes.push_back('{code: emitted[i], last: (i == cnt - 1)});
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eoi);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = b;
    in_end_of_input = eoi;
    compress_byte(b, eoi);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    in_data_byte = BYTE_W'($urandom);
    in_end_of_input = 1'($urandom);
  endtask

  // narrow alphabets give repeats, so prefixes grow through dictionary hits
  task automatic send_stream(input int len, input int alphabet);
    logic [BYTE_W-1:0] base;
    base = BYTE_W'($urandom);
    for (int i = 0; i < len; i++)
      send_byte((alphabet >= 256) ? BYTE_W'($urandom)
                                  : base + BYTE_W'($urandom_range(alphabet - 1)),
                i == len - 1);
  endtask

  task automatic wait_drained();
    while (expected_codes.size() != 0) @(negedge clk);
    repeat (SCAN_WAIT) @(negedge clk);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    for (int i = 0; i < 7; i++) send_byte(8'h61, i == 6);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);  // new pair on the final byte: three codes
    for (int i = 0; i < 8; i++) send_byte((i % 2) ? 8'h55 : 8'haa, i == 7);
    send_byte(8'h0f, 1'b0);
    send_byte(8'hf0, 1'b0);
    send_byte(8'h0f, 1'b0);
    send_byte(8'hf0, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_streams(input int idle_pct, input int stall_pct, input int items);
    int sent;
    int len;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
      if (len > items - sent) len = items - sent;
      case ($urandom_range(3))
        0: send_stream(len, 256);
        1: send_stream(len, 2);
        default: send_stream(len, 4);
      endcase
      sent += len;
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_left = 300;
    send_stream(30, 256);
    send_stream(12, 2);
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    out_stall <= (hold_left > 0) || ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[lzw_byte_compressor_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    code_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_codes.size() == 0) begin
        $error("unexpected word: code %0d last_of_run %0b", out_code, out_last_of_run);
        failed = 1'b1;
      end else begin
        want = expected_codes.pop_front();
        if (out_code !== want.code) begin
          $error("code: expected %0d, got %0d", want.code, out_code);
          failed = 1'b1;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_last_of_run);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_end_of_input = 1'b0;
    out_stall = 1'b0;
    hold_left = 0;
    cycle_count = 0;
    failed = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    clear_dictionary();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_streams(0, 0, 75);
    test_random_streams(78, 0, 55);
    test_random_streams(0, 78, 55);
    test_random_streams(19, 19, 75);
    test_backpressure();

    if (!failed && expected_codes.size() == 0) begin
      $display("[lzw_byte_compressor_top] OK");
    end else begin
      $display("[lzw_byte_compressor_top] ERROR");
    end
    $finish;
  end

endmodule
